/* hdl/pli_pkg.sv */
// Shared types and constants of the piecewise linear interpolator.
`timescale 1ns / 1ps
package pli_pkg;
    localparam int unsigned VAL_W = 32;

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    localparam logic [1:0] ST_INSIDE = 2'd0;
    localparam logic [1:0] ST_EXTRAP = 2'd1;
    localparam logic [1:0] ST_ZERO   = 2'd2;
    localparam logic [1:0] ST_SAT    = 2'd3;

    typedef struct packed {
        logic [VAL_W-1:0] t;
    } t_query;
endpackage

/* hdl/pli_ram.sv */
// Generic single-port-write, one-read RAM with registered read data.
`timescale 1ns / 1ps
module pli_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

/* hdl/pli_front.sv */
// Front end: accepts items, performs table loads and queues queries.
`timescale 1ns / 1ps
module pli_front import pli_pkg::*; #(
    parameter int IDX_W = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic             i_req_type,
    input  logic [3:0]       i_entry_index,
    input  logic [VAL_W-1:0] i_entry_x,
    input  logic [VAL_W-1:0] i_entry_y,
    input  logic [VAL_W-1:0] i_query_x,
    output logic             o_we,
    output logic [IDX_W-1:0] o_waddr,
    output logic [VAL_W-1:0] o_wx,
    output logic [VAL_W-1:0] o_wy,
    output logic             o_q_valid,
    input  logic             i_q_ready,
    output t_query           o_q
);
    // Two-entry query queue.
    t_query r_buf [2];
    logic   r_wp, r_rp;
    logic [1:0] r_cnt;
    logic push, pop, idx_ok;

    // A load waits until no query is queued or running in the back end, so
    // every query sees the table as it stood when the query was accepted.
    assign o_ready = (i_req_type == REQ_LOAD) ? ((r_cnt == 2'd0) && i_q_ready)
                                              : (r_cnt != 2'd2);
    assign push    = i_valid && o_ready && (i_req_type == REQ_QUERY);
    assign pop     = o_q_valid && i_q_ready;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q     = r_buf[r_rp];

    if (IDX_W >= 4) begin : g_idx_full
        assign idx_ok = 1'b1;
    end else begin : g_idx_chk
        assign idx_ok = (i_entry_index[3:IDX_W] == '0);
    end
    assign o_we    = i_valid && o_ready && (i_req_type == REQ_LOAD) && idx_ok;
    assign o_waddr = IDX_W'(i_entry_index);
    assign o_wx    = i_entry_x;
    assign o_wy    = i_entry_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
        if (push) r_buf[r_wp].t <= i_query_x;
    end
endmodule

/* hdl/pli_back.sv */
// Back end: segment search, serial division and result formation.
`timescale 1ns / 1ps
module pli_back import pli_pkg::*; #(
    parameter int IDX_W = 4,
    parameter int MAX_POINTS = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [4:0]       i_point_count,
    input  logic             i_q_valid,
    output logic             o_q_ready,
    input  t_query           i_q,
    output logic [IDX_W-1:0] o_raddr,
    input  logic [VAL_W-1:0] i_rx,
    input  logic [VAL_W-1:0] i_ry,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [VAL_W-1:0] o_result_y,
    output logic [1:0]       o_status
);
    typedef enum logic [7:0] {
        S_IDLE  = 8'b00000001,
        S_SCAN  = 8'b00000010,
        S_LOAD0 = 8'b00000100,
        S_LOAD1 = 8'b00001000,
        S_MUL   = 8'b00010000,
        S_DIV   = 8'b00100000,
        S_FIN   = 8'b01000000,
        S_OUT   = 8'b10000000
    } t_state;

    localparam int CW = IDX_W + 1;

    t_state r_st;
    logic signed [VAL_W-1:0] r_t, r_prev, r_x0, r_y0, r_x1;
    logic [CW-1:0] r_k, r_n, r_seg;
    logic r_found, r_neg;
    logic [1:0] r_sub;
    logic [31:0] r_a, r_b;
    logic [32:0] r_d;
    logic [65:0] r_num;
    logic [32:0] r_rem;
    logic [6:0]  r_cnt;
    logic signed [VAL_W-1:0] r_res;
    logic [1:0] r_stat;

    logic [CW-1:0] n_eff;
    logic signed [VAL_W:0] a_s, b_s, d_s;
    logic [33:0] trial;
    logic [63:0] prod;
    logic signed [42:0] sum;

    always_comb begin
        if (i_point_count < 5'd2) n_eff = CW'(2);
        else if (32'(i_point_count) > MAX_POINTS) n_eff = CW'(MAX_POINTS);
        else n_eff = CW'(i_point_count);
    end

    assign o_q_ready = (r_st == S_IDLE);
    assign o_valid   = (r_st == S_OUT);
    assign o_result_y = r_res;
    assign o_status  = r_stat;

    // Read address: scan walks k; load phases fetch seg and seg+1.
    always_comb begin
        case (r_st)
            S_SCAN:  o_raddr = r_k[IDX_W-1:0];
            S_LOAD0: o_raddr = r_seg[IDX_W-1:0];
            default: o_raddr = IDX_W'(r_seg + CW'(1));
        endcase
    end

    assign a_s = {r_t[31], r_t} - {r_x0[31], r_x0};
    assign b_s = {i_ry[31], i_ry} - {r_y0[31], r_y0};
    assign d_s = {r_x1[31], r_x1} - {r_x0[31], r_x0};
    assign trial = {r_rem, r_num[65]} - {1'b0, r_d};
    // Magnitudes of differences of 32-bit values stay below 2^32.
    assign prod = r_a * r_b;
    // The quotient is at most 2^40 here, so 43 bits hold y0 plus or minus it.
    assign sum = r_neg ? 43'(r_y0) - signed'({2'b00, r_num[40:0]})
                       : 43'(r_y0) + signed'({2'b00, r_num[40:0]});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
        end else begin
            case (r_st)
                S_IDLE: if (i_q_valid) begin
                    r_t <= i_q.t;
                    r_n <= n_eff;
                    r_k <= '0;
                    r_sub <= 2'd0;
                    r_found <= 1'b0;
                    r_st <= S_SCAN;
                end
                // Address k issued in sub-phase 0; its registered read data is used in sub-phase 1.
                S_SCAN: begin
                    if (r_sub == 2'd0) begin
                        r_sub <= 2'd1;
                    end else begin
                        r_sub <= 2'd0;
                        if (r_k == '0) begin
                            r_prev <= i_rx;
                            r_k <= r_k + CW'(1);
                        end else if (r_prev < r_t && r_t <= signed'(i_rx)) begin
                            r_seg <= r_k - CW'(1);
                            r_found <= 1'b1;
                            r_st <= S_LOAD0;
                        end else if (r_k == r_n - CW'(1)) begin
                            r_st <= S_LOAD0;
                        end else begin
                            r_prev <= i_rx;
                            r_k <= r_k + CW'(1);
                        end
                        if (r_k == '0) r_x0 <= i_rx;
                        if (r_k != '0 && !(r_prev < r_t && r_t <= signed'(i_rx))
                            && r_k == r_n - CW'(1))
                            r_seg <= (r_t <= r_x0) ? '0 : r_n - CW'(2);
                    end
                end
                S_LOAD0: begin
                    if (r_sub == 2'd1) begin
                        r_sub <= 2'd0;
                        r_st <= S_LOAD1;
                    end else begin
                        r_sub <= r_sub + 2'd1;
                    end
                end
                S_LOAD1: begin
                    if (r_sub == 2'd0) begin
                        r_x0 <= i_rx;   // data for seg
                        r_y0 <= i_ry;
                        r_sub <= 2'd1;
                    end else begin
                        r_x1 <= i_rx;
                        r_sub <= 2'd0;
                        r_st <= S_MUL;
                    end
                end
                S_MUL: begin
                    // i_ry still holds y[seg+1].
                    r_a <= a_s[32] ? 32'(-a_s) : 32'(a_s);
                    r_b <= b_s[32] ? 32'(-b_s) : 32'(b_s);
                    r_d <= d_s[32] ? 33'(-d_s) : 33'(d_s);
                    r_neg <= (a_s[32] ^ b_s[32]) ^ d_s[32];
                    if (d_s == '0) begin
                        r_res <= r_y0;
                        r_stat <= ST_ZERO;
                        r_st <= S_OUT;
                    end else begin
                        r_cnt <= 7'd0;
                        r_st <= S_FIN;
                    end
                end
                S_FIN: begin
                    // Product: one 32x32 multiply, registered.
                    r_num <= {2'b00, prod};
                    r_rem <= '0;
                    r_cnt <= 7'd0;
                    r_st <= S_DIV;
                end
                S_DIV: begin
                    if (r_cnt == 7'd66) begin
                        if (r_num > 66'h100_0000_0000) begin
                            r_res <= r_neg ? 32'sh8000_0000 : 32'sh7fff_ffff;
                            r_stat <= ST_SAT;
                        end else if (sum > 43'sh7fff_ffff) begin
                            r_res <= 32'sh7fff_ffff;
                            r_stat <= ST_SAT;
                        end else if (sum < -43'sh8000_0000) begin
                            r_res <= 32'sh8000_0000;
                            r_stat <= ST_SAT;
                        end else begin
                            r_res <= sum[31:0];
                            r_stat <= r_found ? ST_INSIDE : ST_EXTRAP;
                        end
                        r_st <= S_OUT;
                    end else begin
                        r_cnt <= r_cnt + 7'd1;
                        if (!trial[33]) begin
                            r_rem <= trial[32:0];
                            r_num <= {r_num[64:0], 1'b1};
                        end else begin
                            r_rem <= {r_rem[31:0], r_num[65]};
                            r_num <= {r_num[64:0], 1'b0};
                        end
                    end
                end
                S_OUT: if (i_ready) r_st <= S_IDLE;
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule

/* hdl/piecewise_linear_interpolator.sv */
// Top level of the piecewise linear interpolator; n is the number of breakpoints in use.
// A query runs as a scan over up to n table entries, a segment fetch, a multiply and a
// 66-step division; a zero-width segment skips the multiply and the division.
// One query runs at a time; the next starts in the cycle after a result is taken, two may queue.
// A load waits until no query is queued or running, then writes the table when accepted.
// i_rst_n is synchronous, active low: it clears control state and sets point_count to 2.
`timescale 1ns / 1ps
module piecewise_linear_interpolator import pli_pkg::*; #(
    parameter int MAX_POINTS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [4:0]  i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata fields from bit 0: entry_index[3:0], entry_x, entry_y, query_x
    input  logic [103:0] s_axis_tdata,
    // tuser fields: req_type
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata fields from bit 0: result_y[31:0]
    output logic [31:0] m_axis_tdata,
    // tuser fields from bit 0: status[1:0]
    output logic [1:0]  m_axis_tuser
);
    localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

    logic [4:0] r_point_count;
    logic we;
    logic [IDX_W-1:0] waddr, raddr;
    logic [VAL_W-1:0] wx, wy, rx, ry;
    logic q_valid, q_ready;
    t_query q;

    // The only configuration register: breakpoints in use.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_point_count <= 5'd2;
        else if (i_cfg_we) r_point_count <= i_cfg_wdata;
    end

    pli_front #(.IDX_W(IDX_W)) u_front (
        .i_clk, .i_rst_n,
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_req_type(s_axis_tuser),
        .i_entry_index(s_axis_tdata[3:0]),
        .i_entry_x(s_axis_tdata[35:4]),
        .i_entry_y(s_axis_tdata[67:36]),
        .i_query_x(s_axis_tdata[99:68]),
        .o_we(we), .o_waddr(waddr), .o_wx(wx), .o_wy(wy),
        .o_q_valid(q_valid), .i_q_ready(q_ready), .o_q(q)
    );

    // Separate x and y tables sharing one read address.
    pli_ram #(.WIDTH(VAL_W), .DEPTH(1 << IDX_W)) u_xram (
        .i_clk, .i_we(we), .i_waddr(waddr), .i_wdata(wx),
        .i_raddr(raddr), .o_rdata(rx)
    );
    pli_ram #(.WIDTH(VAL_W), .DEPTH(1 << IDX_W)) u_yram (
        .i_clk, .i_we(we), .i_waddr(waddr), .i_wdata(wy),
        .i_raddr(raddr), .o_rdata(ry)
    );

    pli_back #(.IDX_W(IDX_W), .MAX_POINTS(MAX_POINTS)) u_back (
        .i_clk, .i_rst_n, .i_point_count(r_point_count),
        .i_q_valid(q_valid), .o_q_ready(q_ready), .i_q(q),
        .o_raddr(raddr), .i_rx(rx), .i_ry(ry),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready),
        .o_result_y(m_axis_tdata), .o_status(m_axis_tuser)
    );

    // A result never appears in the cycle right after reset.
    a_no_out_after_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid) else $error("result right after reset");
    // A saturated result always sits at one of the two signed limits.
    a_sat_limits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == ST_SAT) |->
        (m_axis_tdata == 32'h7fff_ffff || m_axis_tdata == 32'h8000_0000))
        else $error("saturated result not at a limit");
    // A waiting query stays queued until the back end takes it.
    a_queue_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_valid && !q_ready) |=> q_valid) else $error("queued query lost");
endmodule

/* dv/piecewise_linear_interpolator_tb.sv */
// Self-checking testbench of the piecewise linear interpolator: table loads, queries and checks.
`timescale 1ns / 1ps
module piecewise_linear_interpolator_tb;
    import pli_pkg::*;

    localparam int TABLE_DEPTH = 16;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int DRAIN_CYCLES = 200;

    // One row of the directed table. Rows with typed clear use the predictor.
    typedef struct {
        logic        kind;
        logic [3:0]  idx;
        logic [31:0] ex;
        logic [31:0] ey;
        logic [31:0] qx;
        logic        typed;
        logic [31:0] want_y;
        logic [1:0]  want_st;
    } row_t;

    typedef struct {
        logic [31:0] y;
        logic [1:0]  st;
    } answer_t;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_cfg_we = 1'b0;
    logic [4:0]   i_cfg_wdata = '0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [103:0] s_axis_tdata = '0;
    logic         s_axis_tuser = 1'b0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [31:0]  m_axis_tdata;
    logic [1:0]   m_axis_tuser;

    piecewise_linear_interpolator dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
    );

    always #6 i_clk = ~i_clk;

    // Shadow copy of the table and the point count.
    logic signed [31:0] shadow_x [TABLE_DEPTH];
    logic signed [31:0] shadow_y [TABLE_DEPTH];
    bit                 shadow_written [TABLE_DEPTH];
    logic [4:0]         shadow_count;

    answer_t pending_answers[$];
    int      error_count = 0;
    int      cycle_count = 0;

    // Evaluates the curve at t as the block should.
    function automatic answer_t interpolate(logic signed [31:0] t);
        int unsigned n;
        int unsigned seg;
        bit found;
        logic signed [63:0] x0, x1, y0, y1, a, b, d, r;
        logic [63:0] ma, mb, md;
        logic [63:0] q;
        bit neg;
        answer_t ans;
        n = (shadow_count < 2) ? 2 : (shadow_count > TABLE_DEPTH) ? TABLE_DEPTH : shadow_count;
        found = 1'b0;
        seg = 0;
        for (int i = 0; i + 1 < n; i++) begin
            if (!found && shadow_x[i] < t && t <= shadow_x[i+1]) begin
                seg = i;
                found = 1'b1;
            end
        end
        if (!found) seg = (t <= shadow_x[0]) ? 0 : n - 2;
        ans.st = found ? ST_INSIDE : ST_EXTRAP;
        x0 = shadow_x[seg];
        x1 = shadow_x[seg+1];
        y0 = shadow_y[seg];
        y1 = shadow_y[seg+1];
        d = x1 - x0;
        if (d == 0) begin
            ans.y = y0[31:0];
            ans.st = ST_ZERO;
            return ans;
        end
        a = t - x0;
        b = y1 - y0;
        // Unsigned magnitudes: the product can exceed the signed 64-bit range.
        ma = (a < 0) ? -a : a;
        mb = (b < 0) ? -b : b;
        md = (d < 0) ? -d : d;
        q = (ma * mb) / md;
        neg = ((a < 0) != (b < 0)) != (d < 0);
        if (q > 64'd1 << 40) begin
            r = neg ? -64'sd2147483648 : 64'sd2147483647;
            ans.st = ST_SAT;
        end else begin
            r = neg ? y0 - $signed(q) : y0 + $signed(q);
            if (r > 64'sd2147483647) begin
                r = 64'sd2147483647;
                ans.st = ST_SAT;
            end else if (r < -64'sd2147483648) begin
                r = -64'sd2147483648;
                ans.st = ST_SAT;
            end
        end
        ans.y = r[31:0];
        return ans;
    endfunction

    function automatic bit table_ready();
        int unsigned n;
        n = (shadow_count < 2) ? 2 : (shadow_count > TABLE_DEPTH) ? TABLE_DEPTH : shadow_count;
        for (int i = 0; i < n; i++)
            if (!shadow_written[i]) return 1'b0;
        return 1'b1;
    endfunction

    // Drives one transaction, waits for acceptance, then updates the shadow.
    // Valid stays high after acceptance until the next gap or a quiet period.
    task automatic send_item(row_t row);
        answer_t ans;
        int gap;
        gap = $urandom_range(0, 5);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= row.kind;
        s_axis_tdata  <= {row.qx, row.ey, row.ex, row.idx};
        do @(posedge i_clk); while (!s_axis_tready);
        if (row.kind == REQ_LOAD) begin
            shadow_x[row.idx] = row.ex;
            shadow_y[row.idx] = row.ey;
            shadow_written[row.idx] = 1'b1;
        end else begin
            ans = interpolate(row.qx);
            if (row.typed && (ans.y !== row.want_y || ans.st !== row.want_st))
                $display("%0t: directed row disagrees with predictor: typed %h/%0d, predicted %h/%0d",
                         $time, row.want_y, row.want_st, ans.y, ans.st);
            if (row.typed) begin
                ans.y = row.want_y;
                ans.st = row.want_st;
            end
            pending_answers.push_back(ans);
        end
    endtask

    // Writes point_count once the block has gone quiet.
    task automatic set_count(logic [4:0] value);
        s_axis_tvalid <= 1'b0;
        wait (pending_answers.size() == 0);
        repeat (120) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        shadow_count = value;
    endtask

    function automatic row_t load_row(int idx, logic [31:0] x, logic [31:0] y);
        row_t r;
        r = '{REQ_LOAD, idx[3:0], x, y, $urandom, 1'b0, 32'd0, 2'd0};
        return r;
    endfunction

    function automatic row_t query_row(logic [31:0] t);
        row_t r;
        r = '{REQ_QUERY, $urandom_range(0, 15), $urandom, $urandom, t, 1'b0, 32'd0, 2'd0};
        return r;
    endfunction

    function automatic row_t typed_query(logic [31:0] t, logic [31:0] y, logic [1:0] st);
        row_t r;
        r = query_row(t);
        r.typed = 1'b1;
        r.want_y = y;
        r.want_st = st;
        return r;
    endfunction

    // Random value biased toward the extremes and small numbers.
    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return $urandom_range(0, 400) - 200;
            3, 4: return ($urandom_range(0, 2000) - 1000) << 16;
            default: return $urandom;
        endcase
    endfunction

    // Result checker: the receiver stalls at random between transactions.
    initial begin
        answer_t exp_ans;
        int stall;
        wait (i_rst_n);
        forever begin
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            if (pending_answers.size() == 0) begin
                $display("%0t: unexpected result y=%h status=%0d", $time, m_axis_tdata,
                         m_axis_tuser);
                error_count++;
            end else begin
                exp_ans = pending_answers.pop_front();
                if (m_axis_tdata !== exp_ans.y) begin
                    $display("%0t: result_y expected %h actual %h", $time, exp_ans.y,
                             m_axis_tdata);
                    error_count++;
                end
                if (m_axis_tuser !== exp_ans.st) begin
                    $display("%0t: status expected %0d actual %0d", $time, exp_ans.st,
                             m_axis_tuser);
                    error_count++;
                end
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Stimulus.
    initial begin
        row_t directed[$];
        row_t r;
        int counts[5] = '{2, 16, 5, 31, 0};
        int n;
        int phase_items;
        shadow_count = 5'd2;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            shadow_x[i] = '0;
            shadow_y[i] = '0;
            shadow_written[i] = 1'b0;
        end
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part at reset point count: two points (0,0) and (10,100).
        directed.push_back(load_row(0, 32'd0, 32'd0));
        directed.push_back(load_row(1, 32'd10, 32'd100));
        directed.push_back(typed_query(32'd5, 32'd50, ST_INSIDE));
        directed.push_back(typed_query(32'd10, 32'd100, ST_INSIDE));
        directed.push_back(typed_query(32'd0, 32'd0, ST_EXTRAP));
        directed.push_back(typed_query(32'd20, 32'd200, ST_EXTRAP));
        directed.push_back(typed_query(-32'sd3, -32'sd30, ST_EXTRAP));
        directed.push_back(typed_query(32'h7FFF_FFFF, 32'h7FFF_FFFF, ST_SAT));
        directed.push_back(typed_query(32'h8000_0000, 32'h8000_0000, ST_SAT));
        // Truncation toward zero with a negative slope.
        directed.push_back(load_row(1, 32'd3, -32'sd10));
        directed.push_back(query_row(32'd1));
        directed.push_back(query_row(-32'sd1));
        // Zero-width segment.
        directed.push_back(load_row(1, 32'd0, 32'd77));
        directed.push_back(typed_query(32'd9, 32'd0, ST_ZERO));
        // Unsorted table: negative width.
        directed.push_back(load_row(0, 32'h7FFF_FFFF, 32'h8000_0000));
        directed.push_back(load_row(1, 32'h8000_0000, 32'h7FFF_FFFF));
        directed.push_back(query_row(32'd0));
        directed.push_back(query_row(32'h7FFF_FFFF));
        directed.push_back(query_row(32'h8000_0000));
        // Index out of the used range still loads an entry.
        directed.push_back(load_row(15, 32'hFFFF_FFFF, 32'h0001_0000));
        foreach (directed[i]) send_item(directed[i]);

        // Random phases over several point counts.
        for (int p = 0; p < 10; p++) begin
            set_count(p < 5 ? counts[p][4:0] : $urandom_range(0, 31));
            n = (shadow_count < 2) ? 2 : (shadow_count > TABLE_DEPTH) ? TABLE_DEPTH : shadow_count;
            // Mostly sorted table of random content.
            begin
                logic signed [31:0] xv;
                xv = $urandom_range(0, 1) ? pick_value() : -32'sd1000 <<< 16;
                for (int i = 0; i < n; i++) begin
                    send_item(load_row(i, xv, pick_value()));
                    if ($urandom_range(0, 9) == 0) xv = pick_value();
                    else if (xv < 32'sh7000_0000)
                        xv = xv + ($urandom_range(0, 9) == 0 ? 0 : $urandom_range(1, 1 << 24));
                end
            end
            phase_items = 180;
            for (int k = 0; k < phase_items; k++) begin
                if ($urandom_range(0, 4) == 0) begin
                    r = load_row($urandom_range(0, 15), pick_value(), pick_value());
                end else begin
                    r = query_row($urandom_range(0, 2) == 0 ? pick_value()
                        : shadow_x[$urandom_range(0, n - 1)] + $urandom_range(0, 64) - 32);
                end
                if (r.kind == REQ_QUERY && !table_ready()) continue;
                send_item(r);
            end
        end

        s_axis_tvalid <= 1'b0;
        wait (pending_answers.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
